>>> rtl/core/key_click_classifier_macros.svh
// Assertion macros for the key click classifier.
// Used by the top level key_click_classifier.sv; expects clk and rst in scope.
`ifndef KEY_CLICK_CLASSIFIER_MACROS_SVH
`define KEY_CLICK_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define KCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define KCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KCC_ASSERT_SAME(lbl, ante, cons, msg)
`define KCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/kcc_pkg.sv
// Shared types and constants of the key click classifier.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package kcc_pkg;

  // Number of key records; reported_key is three bits wide
  localparam int unsigned KEY_COUNT = 6;

  // Input command codes
  localparam logic CMD_QUEUE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  // Edge request codes
  localparam logic EDGE_PRESS   = 1'b0;
  localparam logic EDGE_RELEASE = 1'b1;

  // Reported event kind codes
  localparam logic [1:0] EK_HIT    = 2'd0;
  localparam logic [1:0] EK_DOUBLE = 2'd1;
  localparam logic [1:0] EK_LONG   = 2'd2;

  // Register map
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_DELAY  = 2'd1;
  localparam logic [1:0] REG_LPUSH  = 2'd2;

  localparam logic [15:0] WINDOW_RESET = 16'd160;
  localparam logic [15:0] DELAY_RESET  = 16'd200;
  localparam logic [15:0] LPUSH_RESET  = 16'd1000;

  // Queued event kinds
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_ERROR   = 2'd2
  } ev_t;

  // Per-key record kinds
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_DHIT  = 2'd2,
    KIND_LPUSH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic [15:0] window;
    logic [15:0] delay;
    logic [15:0] lpush;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic push;
    logic pop;
    logic time_load;
    logic scan_init;
    logic apply;
    logic clear_all;
    logic scan_adv;
    logic emit_last;
  } ctrl_cmd_t;

  // Key datapath to controller
  typedef struct packed {
    logic entry_bad;
    logic entry_clear;
    logic step_report;
    logic scan_last;
    logic pend_valid;
    logic out_free;
  } keys_status_t;

endpackage

`default_nettype wire

>>> rtl/core/key_click_classifier.sv
// Top level of the key click classifier: registers, queue, key datapath, controller.
// Depends on kcc_pkg, key_click_classifier_macros.svh and all kcc_* modules.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | command, key_number, edge_req, time_ms
//   out      | out_valid / out_ready| reported_key, event_kind, released, last
//   config   | psel/penable/pready  | paddr, pwdata, prdata
//
// A queue word (command 0) is taken directly in the idle state. A run step pops
// an event if the queue holds one, applies it, scans the key records and ends
// with a flush; an empty queue skips the apply, and an out-of-range key ends the
// step after the apply. The scan walks the records one per cycle while no new
// report waits on out_ready; the flush waits on out_ready for the held report.
// Synchronous reset clears the queue pointers, key records and config to defaults.
`default_nettype none

module key_click_classifier #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [kcc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               command,
  input  wire logic [7:0]                         key_number,
  input  wire logic                               edge_req,
  input  wire logic [TIME_BITS-1:0]               time_ms,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [2:0]                         reported_key,
  output logic      [1:0]                         event_kind,
  output logic                                    released,
  output logic                                    last
);
  import kcc_pkg::*;

`include "key_click_classifier_macros.svh"

  cfg_t                 cfg;
  ctrl_cmd_t            cmd;
  keys_status_t         st;
  logic                 q_empty;
  logic [7:0]           entry_key;
  ev_t                  entry_ev;
  logic [TIME_BITS-1:0] entry_time;
  logic [TIME_BITS-1:0] step_time;

  // Run-step time, taken when the step is accepted
  always_ff @(posedge clk) begin
    if (cmd.time_load) begin
      step_time <= time_ms;
    end
  end

  kcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push_key  (key_number),
    .push_edge (edge_req),
    .push_time (time_ms),
    .empty     (q_empty),
    .rd_key    (entry_key),
    .rd_ev     (entry_ev),
    .rd_time   (entry_time)
  );

  kcc_keys #(
    .TIME_BITS (TIME_BITS)
  ) u_keys (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .time_ms      (step_time),
    .entry_key    (entry_key),
    .entry_ev     (entry_ev),
    .entry_time   (entry_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reported_key (reported_key),
    .event_kind   (event_kind),
    .released     (released),
    .last         (last)
  );

  kcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .q_empty  (q_empty),
    .st       (st),
    .cmd      (cmd)
  );

  // After a run step is accepted, the input is closed in the next cycle
  `KCC_ASSERT_NEXT(a_run_busy, in_valid && in_ready && (command == CMD_RUN), !in_ready, "input open right after a run step")
  // No held report is left behind once the controller is idle
  `KCC_ASSERT_SAME(a_idle_no_pend, in_ready, !st.pend_valid, "held report left at end of step")
  // A queued word always leaves the queue non-empty
  `KCC_ASSERT_NEXT(a_push_fill, cmd.push, !q_empty, "queue empty after push")

endmodule

`default_nettype wire

>>> rtl/core/kcc_regs.sv
// Configuration registers behind the APB-style port.
// Depends on kcc_pkg for the register map and reset values.
`default_nettype none

module kcc_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [kcc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output kcc_pkg::cfg_t                           cfg
);
  import kcc_pkg::*;

  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window <= WINDOW_RESET;
      cfg.delay  <= DELAY_RESET;
      cfg.lpush  <= LPUSH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW: cfg.window <= pwdata[15:0];
        REG_DELAY:  cfg.delay  <= pwdata[15:0];
        REG_LPUSH:  cfg.lpush  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = {16'd0, cfg.window};
      REG_DELAY:  prdata = {16'd0, cfg.delay};
      REG_LPUSH:  prdata = {16'd0, cfg.lpush};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/kcc_queue.sv
// Circular event queue with drop-oldest overflow and registered read.
// Depends on kcc_pkg for the event kinds and command struct.
`default_nettype none

module kcc_queue #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  kcc_pkg::ctrl_cmd_t         cmd,
  input  wire logic [7:0]            push_key,
  input  wire logic                  push_edge,
  input  wire logic [TIME_BITS-1:0]  push_time,
  output logic                       empty,
  output logic      [7:0]            rd_key,
  output kcc_pkg::ev_t               rd_ev,
  output logic      [TIME_BITS-1:0]  rd_time
);
  import kcc_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic [7:0]           mem_key  [QUEUE_DEPTH];
  ev_t                  mem_ev   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] mem_time [QUEUE_DEPTH];

  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] fill;
  logic          full;
  ev_t           push_ev;

  assign fill  = wr_ptr - rd_ptr;
  assign full  = (fill == {PW{1'b1}});
  assign empty = (fill == '0);

  // Replace the new word by an error event when full
  always_comb begin
    if (full) begin
      push_ev = EV_ERROR;
    end else if (push_edge == EDGE_RELEASE) begin
      push_ev = EV_RELEASE;
    end else begin
      push_ev = EV_PRESS;
    end
  end

  // Advance pointers; drop the oldest word on overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= wr_ptr + PW'(1);
        if (full) begin
          rd_ptr <= rd_ptr + PW'(1);
        end
      end else if (cmd.pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_key[wr_ptr]  <= push_key;
      mem_ev[wr_ptr]   <= push_ev;
      mem_time[wr_ptr] <= push_time;
    end
    if (cmd.pop) begin
      rd_key  <= mem_key[rd_ptr];
      rd_ev   <= mem_ev[rd_ptr];
      rd_time <= mem_time[rd_ptr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kcc_keys.sv
// Key record datapath: event apply, per-key scan and the result registers.
// Depends on kcc_pkg for record kinds, config and command/status structs.
`default_nettype none

module kcc_keys #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  kcc_pkg::cfg_t              cfg,
  input  kcc_pkg::ctrl_cmd_t         cmd,
  output kcc_pkg::keys_status_t      st,
  input  wire logic [TIME_BITS-1:0]  time_ms,
  input  wire logic [7:0]            entry_key,
  input  kcc_pkg::ev_t               entry_ev,
  input  wire logic [TIME_BITS-1:0]  entry_time,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [2:0]            reported_key,
  output logic      [1:0]            event_kind,
  output logic                       released,
  output logic                       last
);
  import kcc_pkg::*;

  localparam int unsigned IW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  kind_t                kind_r  [KEY_COUNT];
  logic                 rel_r   [KEY_COUNT];
  logic [TIME_BITS-1:0] stamp_r [KEY_COUNT];

  logic [TIME_BITS-1:0] t_now;
  logic [IW-1:0]        scan_idx;
  logic                 due_seen;
  logic                 pend_valid;
  logic [2:0]           pend_key;
  logic [1:0]           pend_kind;
  logic                 pend_rel;

  logic [7:0]           key_m1;
  logic [IW-1:0]        apply_idx;
  logic [IW-1:0]        rec_idx;
  logic                 key_zero;
  kind_t                cur_kind;
  logic                 cur_rel;
  logic [TIME_BITS-1:0] cur_stamp;
  logic [TIME_BITS-1:0] spacing;
  logic [TIME_BITS-1:0] age;
  logic                 active;
  logic                 due;
  kind_t                kind_new;
  logic                 report;
  logic [1:0]           kind_code;
  logic [7:0]           key_num;
  logic                 emit;

  // Pick the record: popped key while applying, else the scan position
  assign key_m1    = entry_key - 8'd1;
  assign apply_idx = key_m1[IW-1:0];
  assign rec_idx   = cmd.apply ? apply_idx : scan_idx;
  assign key_zero  = (entry_key == 8'd0);
  assign cur_kind  = kind_r[rec_idx];
  assign cur_rel   = rel_r[rec_idx];
  assign cur_stamp = stamp_r[rec_idx];

  // Apply path: press spacing against the stamp
  assign spacing = entry_time - cur_stamp;

  // Scan path: age against the step time, due test, long push promotion
  assign t_now    = time_ms;
  assign age      = t_now - cur_stamp;
  assign active   = (cur_kind != KIND_NONE) || cur_rel;
  assign due      = active && ((age > TIME_BITS'(cfg.delay)) || due_seen);
  assign kind_new = (!cur_rel && (age > TIME_BITS'(cfg.lpush))) ? KIND_LPUSH : cur_kind;
  assign report   = due && (cur_rel || (kind_new == KIND_LPUSH)) && (kind_new != KIND_NONE);
  assign key_num  = 8'(scan_idx) + 8'd1;

  always_comb begin
    case (kind_new)
      KIND_HIT:   kind_code = EK_HIT;
      KIND_DHIT:  kind_code = EK_DOUBLE;
      KIND_LPUSH: kind_code = EK_LONG;
      default:    kind_code = EK_HIT;
    endcase
  end

  assign emit = (cmd.scan_adv && report && pend_valid) || cmd.emit_last;

  // Status to the controller
  assign st.entry_bad   = (entry_key > 8'(KEY_COUNT));
  assign st.entry_clear = (entry_ev == EV_ERROR) && !key_zero && !st.entry_bad;
  assign st.step_report = report;
  assign st.scan_last   = (scan_idx == IW'(KEY_COUNT - 1));
  assign st.pend_valid  = pend_valid;
  assign st.out_free    = !out_valid || out_ready;

  // Key records
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        kind_r[i]  <= KIND_NONE;
        rel_r[i]   <= 1'b0;
        stamp_r[i] <= '0;
      end
    end else if (cmd.apply && !key_zero) begin
      case (entry_ev)
        EV_PRESS: begin
          if (cur_kind == KIND_HIT) begin
            if (spacing < TIME_BITS'(cfg.window)) begin
              kind_r[rec_idx] <= KIND_DHIT;
            end else begin
              kind_r[rec_idx]  <= KIND_HIT;
              stamp_r[rec_idx] <= entry_time;
            end
            rel_r[rec_idx] <= 1'b0;
          end else if ((cur_kind == KIND_NONE) && !cur_rel) begin
            kind_r[rec_idx]  <= KIND_HIT;
            stamp_r[rec_idx] <= entry_time;
          end
        end
        EV_RELEASE: rel_r[rec_idx] <= 1'b1;
        default: ;
      endcase
    end else if (cmd.scan_adv && due) begin
      if (cur_rel) begin
        kind_r[rec_idx]  <= KIND_NONE;
        rel_r[rec_idx]   <= 1'b0;
        stamp_r[rec_idx] <= '0;
      end else begin
        kind_r[rec_idx] <= kind_new;
      end
    end
  end

  // Scan control and result handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      due_seen   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        scan_idx   <= '0;
        due_seen   <= 1'b0;
        pend_valid <= 1'b0;
      end else if (cmd.scan_adv) begin
        scan_idx <= scan_idx + IW'(1);
        due_seen <= due_seen || due;
        if (report) begin
          pend_valid <= 1'b1;
        end
      end else if (cmd.emit_last) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold one report back so the step's final word can be flagged
  always_ff @(posedge clk) begin
    if (emit) begin
      reported_key <= pend_key;
      event_kind   <= pend_kind;
      released     <= pend_rel;
      last         <= cmd.emit_last;
    end
    if (cmd.scan_adv && report) begin
      pend_key  <= key_num[2:0];
      pend_kind <= kind_code;
      pend_rel  <= cur_rel;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kcc_ctrl.sv
// Run-step controller: sequences queue, apply, scan and final flush.
// Depends on kcc_pkg for the state type and command/status structs.
`default_nettype none

module kcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              command,
  output logic                   in_ready,
  input  wire logic              q_empty,
  input  kcc_pkg::keys_status_t  st,
  output kcc_pkg::ctrl_cmd_t     cmd
);
  import kcc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        stall;

  // A new report may not push out the held one while the output is full
  assign stall = st.step_report && st.pend_valid && !st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (command == CMD_RUN)) begin
          state_next = q_empty ? ST_SCAN : ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = st.entry_bad ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall && st.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st.pend_valid || st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_QUEUE) begin
            cmd.push = 1'b1;
          end else begin
            cmd.time_load = 1'b1;
            cmd.scan_init = 1'b1;
            cmd.pop       = !q_empty;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply     = !st.entry_bad;
        cmd.clear_all = !st.entry_bad && st.entry_clear;
      end
      ST_SCAN: begin
        cmd.scan_adv = !stall;
      end
      ST_FLUSH: begin
        cmd.emit_last = st.pend_valid && st.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> tb/kcc_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the key click classifier testbench: a behavioral predictor
// of the edge queue and key records plus the store of expected reports.
// Depends on kcc_pkg for command, edge, event and register codes.
package kcc_tb_pkg;
  import kcc_pkg::*;

  localparam int KEYS  = 6;
  localparam int SLOTS = 8;

  typedef struct packed {
    logic [7:0]  key;
    ev_t         ev;
    logic [31:0] stamp;
  } edge_word_t;

  typedef struct packed {
    logic [2:0] key;
    logic [1:0] kind;
    logic       rel;
    logic       last;
  } click_report_t;

  class click_scoreboard;
    edge_word_t    edge_fifo[SLOTS];
    logic [2:0]    rd_ptr;
    logic [2:0]    wr_ptr;
    kind_t         key_state[KEYS];
    logic          key_up[KEYS];
    logic [31:0]   key_stamp[KEYS];
    logic [15:0]   window;
    logic [15:0]   delay;
    logic [15:0]   lpush;
    click_report_t due[$];
    int            errors;

    function new();
      clear_keys();
      window = WINDOW_RESET;
      delay  = DELAY_RESET;
      lpush  = LPUSH_RESET;
      errors = 0;
    endfunction

    // Drop every key record and empty the edge queue
    function void clear_keys();
      rd_ptr = '0;
      wr_ptr = '0;
      for (int i = 0; i < KEYS; i++) begin
        key_state[i] = KIND_NONE;
        key_up[i]    = 1'b0;
        key_stamp[i] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_WINDOW: window = value;
        REG_DELAY:  delay  = value;
        REG_LPUSH:  lpush  = value;
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Predict the reports caused by one accepted input word
    function void take_word(logic cmd, logic [7:0] key, logic edge_bit, logic [31:0] now_ms);
      edge_word_t    e;
      ev_t           ev;
      logic [2:0]    fill;
      logic [31:0]   age;
      click_report_t r;
      int            k;
      int            n;
      bit            handling;

      // Queue an edge; on a full queue drop the oldest and queue an error instead
      if (cmd == CMD_QUEUE) begin
        ev = (edge_bit == EDGE_RELEASE) ? EV_RELEASE : EV_PRESS;
        fill = wr_ptr - rd_ptr;
        if (fill == 3'(SLOTS - 1)) begin
          rd_ptr = rd_ptr + 3'd1;
          ev = EV_ERROR;
        end
        e.key = key;
        e.ev = ev;
        e.stamp = now_ms;
        edge_fifo[wr_ptr] = e;
        wr_ptr = wr_ptr + 3'd1;
        return;
      end

      // Pop at most one edge and apply it to its key
      if (wr_ptr != rd_ptr) begin
        e = edge_fifo[rd_ptr];
        rd_ptr = rd_ptr + 3'd1;
        if (e.key > KEYS) return;
        if (e.key != 8'd0) begin
          k = int'(e.key) - 1;
          case (e.ev)
            EV_PRESS: begin
              if (key_state[k] == KIND_HIT) begin
                age = e.stamp - key_stamp[k];
                if (age < 32'(window)) begin
                  key_state[k] = KIND_DHIT;
                end else begin
                  key_state[k] = KIND_HIT;
                  key_stamp[k] = e.stamp;
                end
                key_up[k] = 1'b0;
              end else if (key_state[k] == KIND_NONE && !key_up[k]) begin
                key_state[k] = KIND_HIT;
                key_stamp[k] = e.stamp;
              end
            end
            EV_RELEASE: key_up[k] = 1'b1;
            default: clear_keys();
          endcase
        end
      end

      // Scan in key order; once one key is due, every later pending key is handled
      n = 0;
      handling = 1'b0;
      for (int i = 0; i < KEYS; i++) begin
        if (key_state[i] == KIND_NONE && !key_up[i]) continue;
        age = now_ms - key_stamp[i];
        if (!(age > 32'(delay) || handling)) continue;
        handling = 1'b1;
        if (!key_up[i] && age > 32'(lpush)) key_state[i] = KIND_LPUSH;
        if ((key_up[i] || key_state[i] == KIND_LPUSH) && key_state[i] != KIND_NONE) begin
          r.key  = 3'(i + 1);
          r.kind = key_state[i] - 2'd1;
          r.rel  = key_up[i];
          r.last = 1'b0;
          due.push_back(r);
          n++;
        end
        if (key_up[i]) begin
          key_state[i] = KIND_NONE;
          key_up[i]    = 1'b0;
          key_stamp[i] = '0;
        end
      end
      if (n > 0) begin
        r = due[due.size() - 1];
        r.last = 1'b1;
        due[due.size() - 1] = r;
      end
    endfunction

    // Compare one accepted report word with the oldest expectation
    function void check_word(logic [2:0] key, logic [1:0] kind, logic rel, logic lst);
      click_report_t want;
      if (due.size() == 0) begin
        report($sformatf("report key %0d kind %0d with nothing expected", key, kind));
        return;
      end
      want = due.pop_front();
      if (key !== want.key)
        report($sformatf("reported_key %0d, expected %0d", key, want.key));
      if (kind !== want.kind)
        report($sformatf("key %0d event_kind %0d, expected %0d", want.key, kind, want.kind));
      if (rel !== want.rel)
        report($sformatf("key %0d released %0b, expected %0b", want.key, rel, want.rel));
      if (lst !== want.last)
        report($sformatf("key %0d last %0b, expected %0b", want.key, lst, want.last));
    endfunction
  endclass
endpackage

>>> tb/key_click_classifier_tb.sv
`timescale 1ns / 1ps
// Top-level testbench of the key click classifier: drives edge and step words,
// programs the timing registers over APB and checks every report word.
// Depends on kcc_pkg, kcc_tb_pkg (tb/kcc_scoreboard.sv) and the key_click_classifier RTL.
module key_click_classifier_tb;
  import kcc_pkg::*;
  import kcc_tb_pkg::*;

  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 18;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [APB_ADDR_BITS-1:0]      paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic                          command;
  logic [7:0]                    key_number;
  logic                          edge_req;
  logic [31:0]                   time_ms;
  logic                          out_valid;
  logic                          out_ready;
  logic [2:0]                    reported_key;
  logic [1:0]                    event_kind;
  logic                          released;
  logic                          last;

  click_scoreboard sb;
  logic [31:0]     now_ms;
  logic            key_held [1:KEYS];
  bit              no_idle;
  int              hold_left;
  int              quiet_cycles;

  key_click_classifier DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .key_number(key_number),
    .edge_req(edge_req),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .reported_key(reported_key),
    .event_kind(event_kind),
    .released(released),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Time step scaled to one of the programmed windows
  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40);
      1: return $urandom_range(0, sb.window + 40);
      2: return $urandom_range(0, sb.delay + 40);
      default: return $urandom_range(0, sb.lpush + 40);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Sample both channels at the rising edge; stop if nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_word(reported_key, event_kind, released, last);
      if (in_valid && in_ready) sb.take_word(command, key_number, edge_req, time_ms);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one input word and hold it until it is taken
  task automatic send_word(logic cmd, logic [7:0] key, logic edge_bit, logic [31:0] t);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command    = cmd;
    key_number = key;
    edge_req   = edge_bit;
    time_ms    = t;
    in_valid   = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_edge(logic [7:0] key, logic edge_bit, logic [31:0] t);
    send_word(CMD_QUEUE, key, edge_bit, t);
  endtask

  // Key and edge bits are don't-care on a step, so toggle them anyway
  task automatic run_step(logic [31:0] t);
    send_word(CMD_RUN, 8'($urandom), 1'($urandom), t);
  endtask

  // Write one register, then read it back
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== value)
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, prdata[15:0], value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Drop valid, wait for every expected report, then let the step finish
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          phase;
    int          sent;
    int          r;
    int          k;
    int          burst;
    logic [15:0] cfg [3];

    sb = new();
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    command      = CMD_QUEUE;
    key_number   = '0;
    edge_req     = EDGE_PRESS;
    time_ms      = '0;
    now_ms       = '0;
    no_idle      = 1'b0;
    hold_left    = 0;
    quiet_cycles = 0;
    for (int i = 1; i <= KEYS; i++) key_held[i] = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Step on an empty queue
    run_step(32'd0);
    // Overfill the queue; the error word carries an out-of-range key and max time
    queue_edge(8'd5, EDGE_PRESS, 32'd50);
    queue_edge(8'd1, EDGE_PRESS, 32'd100);
    queue_edge(8'd1, EDGE_PRESS, 32'd150);
    queue_edge(8'd1, EDGE_PRESS, 32'd160);
    queue_edge(8'd1, EDGE_RELEASE, 32'd200);
    queue_edge(8'd3, EDGE_RELEASE, 32'd210);
    queue_edge(8'd0, EDGE_PRESS, 32'd220);
    queue_edge(8'hff, EDGE_RELEASE, 32'hffff_ffff);
    // Pop them: hit, double hit, press on a double hit, release reported,
    // release with no hit, key zero, then the bad key ending the step
    for (int i = 0; i < 7; i++) run_step(32'd400 + 32'(i * 10));
    // Long push held across steps, press on it, then released
    queue_edge(8'd2, EDGE_PRESS, 32'd1000);
    run_step(32'd1000);
    run_step(32'd2100);
    queue_edge(8'd2, EDGE_PRESS, 32'd2150);
    queue_edge(8'd2, EDGE_RELEASE, 32'd2200);
    run_step(32'd2200);
    run_step(32'd2210);
    // Second press outside the window makes a fresh hit; then step at max time
    queue_edge(8'd4, EDGE_PRESS, 32'd3000);
    queue_edge(8'd4, EDGE_PRESS, 32'd3300);
    run_step(32'd3300);
    run_step(32'd3300);
    run_step(32'hffff_ffff);

    now_ms = $urandom;
    for (phase = 0; phase < 5; phase++) begin
      // Reprogram only with nothing in flight
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: begin
            cfg = '{16'hffff, 16'd0, 16'd0};
            now_ms = 32'hffff_f000;
          end
          2: cfg = '{16'd0, 16'hffff, 16'hffff};
          3: cfg = '{16'($urandom_range(1, 400)), 16'($urandom_range(1, 600)),
                     16'($urandom_range(200, 3000))};
          default: cfg = '{WINDOW_RESET, DELAY_RESET, LPUSH_RESET};
        endcase
        write_reg(REG_WINDOW, cfg[0]);
        write_reg(REG_DELAY, cfg[1]);
        write_reg(REG_LPUSH, cfg[2]);
      end
      no_idle = (phase == 3);

      if (phase == 4) begin
        // Empty the edge queue so that six presses all fit
        repeat (7) run_step(now_ms);
        for (k = 1; k <= KEYS; k++) begin
          queue_edge(8'(k), EDGE_PRESS, now_ms);
          key_held[k] = 1'b1;
        end
        repeat (6) run_step(now_ms);
        // Hold the output off while steps keep reporting long pushes
        hold_left = HOLD_CYCLES;
        now_ms = now_ms + 32'(LPUSH_RESET);
        repeat (12) begin
          now_ms = now_ms + 32'd1;
          run_step(now_ms);
        end
        for (k = 1; k <= KEYS; k++) begin
          queue_edge(8'(k), EDGE_RELEASE, now_ms);
          key_held[k] = 1'b0;
        end
        repeat (6) run_step(now_ms);
      end

      // Mostly press/release pairs and steps, some bursts, some noise
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          burst = $urandom_range(8, 10);
          repeat (burst) queue_edge(8'($urandom_range(1, KEYS)), 1'($urandom), now_ms);
          sent += burst;
        end else if (r < 48) begin
          now_ms = now_ms + pick_dt();
          run_step(now_ms);
          sent++;
        end else if (r < 88) begin
          k = $urandom_range(1, KEYS);
          now_ms = now_ms + pick_dt();
          queue_edge(8'(k), key_held[k] ? EDGE_RELEASE : EDGE_PRESS, now_ms);
          key_held[k] = !key_held[k];
          sent++;
        end else begin
          if ($urandom_range(0, 1) == 0) queue_edge(8'($urandom), 1'($urandom), $urandom);
          else run_step($urandom);
          sent++;
        end
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
